// ===== rtl/quaternion_to_rotation_matrix_unit_assert.svh =====
// Assertion macros for the quaternion to rotation matrix unit
`ifndef QUATERNION_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH

// Implication checked at every edge outside reset
`define QRM_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// Consequent checked after the delay given by argument n
`define QRM_ASSERT_DLY(lbl, a, n, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) else $error(msg);

`endif

// ===== rtl/qrm_pkg.sv =====
`default_nettype none
package qrm_pkg;
  // Components wider than this are cut to their top bits
  localparam int KEEP_BITS = 30;
  // Matrix entries, column-major
  localparam int N_ENTRY   = 9;
  localparam int E_C0X = 0;
  localparam int E_C0Y = 1;
  localparam int E_C0Z = 2;
  localparam int E_C1X = 3;
  localparam int E_C1Y = 4;
  localparam int E_C1Z = 5;
  localparam int E_C2X = 6;
  localparam int E_C2Y = 7;
  localparam int E_C2Z = 8;
endpackage
`default_nettype wire

// ===== rtl/quaternion_to_rotation_matrix_unit.sv =====
`default_nettype none
// Quaternion to 3x3 rotation matrix. One quaternion may be started in every
// cycle (busy stays low) and its nine entries appear with out_valid after
// three stages for the component register, products and sums, then a
// restoring divider of nine lanes that resolves one quotient bit per stage,
// its last stage also rounding, and the output register. The receiver
// cannot stall; each result is shown for one cycle only. A zero quaternion
// yields the identity with out_zero_norm set.
`include "quaternion_to_rotation_matrix_unit_assert.svh"
module quaternion_to_rotation_matrix_unit #(
  parameter int IN_WIDTH  = 16,
  parameter int OUT_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [IN_WIDTH-1:0]  in_qw,
  input  wire logic signed [IN_WIDTH-1:0]  in_qx,
  input  wire logic signed [IN_WIDTH-1:0]  in_qy,
  input  wire logic signed [IN_WIDTH-1:0]  in_qz,
  output logic                             out_valid,
  output logic signed [OUT_WIDTH-1:0]      out_col0_x,
  output logic signed [OUT_WIDTH-1:0]      out_col0_y,
  output logic signed [OUT_WIDTH-1:0]      out_col0_z,
  output logic signed [OUT_WIDTH-1:0]      out_col1_x,
  output logic signed [OUT_WIDTH-1:0]      out_col1_y,
  output logic signed [OUT_WIDTH-1:0]      out_col1_z,
  output logic signed [OUT_WIDTH-1:0]      out_col2_x,
  output logic signed [OUT_WIDTH-1:0]      out_col2_y,
  output logic signed [OUT_WIDTH-1:0]      out_col2_z,
  output logic                             out_zero_norm
);
  localparam int CW   = (IN_WIDTH > qrm_pkg::KEEP_BITS) ? qrm_pkg::KEEP_BITS : IN_WIDTH;
  localparam int PW   = 2 * CW;
  localparam int NW   = PW + 2;
  localparam int DW   = PW + 1;
  localparam int RW   = DW + 1;
  localparam int QW   = OUT_WIDTH;
  localparam int FRAC = OUT_WIDTH - 2;
  localparam int NST  = FRAC + 2;
  localparam int LAT  = FRAC + 6;
  localparam int NE   = qrm_pkg::N_ENTRY;

  assign busy = 1'b0;

  // component register
  logic                 v0_r;
  logic signed [CW-1:0] w_r, x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
    w_r <= in_qw[IN_WIDTH-1 -: CW];
    x_r <= in_qx[IN_WIDTH-1 -: CW];
    y_r <= in_qy[IN_WIDTH-1 -: CW];
    z_r <= in_qz[IN_WIDTH-1 -: CW];
  end

  // products
  logic                 v1_r;
  logic signed [PW-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    ww_r <= PW'(w_r) * PW'(w_r);
    xx_r <= PW'(x_r) * PW'(x_r);
    yy_r <= PW'(y_r) * PW'(y_r);
    zz_r <= PW'(z_r) * PW'(z_r);
    xy_r <= PW'(x_r) * PW'(y_r);
    xz_r <= PW'(x_r) * PW'(z_r);
    yz_r <= PW'(y_r) * PW'(z_r);
    wx_r <= PW'(w_r) * PW'(x_r);
    wy_r <= PW'(w_r) * PW'(y_r);
    wz_r <= PW'(w_r) * PW'(z_r);
  end

  // numerators and norm
  logic signed [NW-1:0] eww, exx, eyy, ezz, exy, exz, eyz, ewx, ewy, ewz;
  logic signed [NW-1:0] num_nxt [0:NE-1];
  logic signed [NW-1:0] num_r   [0:NE-1];
  logic [DW-1:0]        den_nxt, den2_r;
  logic                 v2_r;

  always_comb begin
    eww = NW'(ww_r);
    exx = NW'(xx_r);
    eyy = NW'(yy_r);
    ezz = NW'(zz_r);
    exy = NW'(xy_r);
    exz = NW'(xz_r);
    eyz = NW'(yz_r);
    ewx = NW'(wx_r);
    ewy = NW'(wy_r);
    ewz = NW'(wz_r);
    num_nxt[qrm_pkg::E_C0X] = eww + exx - eyy - ezz;
    num_nxt[qrm_pkg::E_C0Y] = (exy + ewz) <<< 1;
    num_nxt[qrm_pkg::E_C0Z] = (exz - ewy) <<< 1;
    num_nxt[qrm_pkg::E_C1X] = (exy - ewz) <<< 1;
    num_nxt[qrm_pkg::E_C1Y] = eww - exx + eyy - ezz;
    num_nxt[qrm_pkg::E_C1Z] = (eyz + ewx) <<< 1;
    num_nxt[qrm_pkg::E_C2X] = (exz + ewy) <<< 1;
    num_nxt[qrm_pkg::E_C2Y] = (eyz - ewx) <<< 1;
    num_nxt[qrm_pkg::E_C2Z] = eww - exx - eyy + ezz;
    den_nxt = DW'(eww + exx + eyy + ezz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    num_r  <= num_nxt;
    den2_r <= den_nxt;
  end

  // divider: one quotient bit per stage, last stage rounds
  logic [RW-1:0] rem_r   [0:NST-1][0:NE-1];
  logic [RW-1:0] rem_nxt [0:NST-1][0:NE-1];
  logic [QW-1:0] quo_r   [0:NST-1][0:NE-1];
  logic [QW-1:0] quo_nxt [0:NST-1][0:NE-1];
  logic          neg_r   [0:NST-1][0:NE-1];
  logic          neg_nxt [0:NST-1][0:NE-1];
  logic [DW-1:0] dd_r    [0:NST-1];
  logic          zn_r    [0:NST-1];
  logic          vd_r    [0:NST-1];

  genvar gs, ge;
  generate
    for (gs = 0; gs < NST; gs++) begin : g_stage
      for (ge = 0; ge < NE; ge++) begin : g_lane
        logic [RW-1:0] sh;
        logic [RW-1:0] dx;
        logic          bit_q;
        if (gs == 0) begin : g_first
          always_comb begin
            neg_nxt[gs][ge] = num_r[ge][NW-1];
            sh = num_r[ge][NW-1] ? RW'(-num_r[ge]) : RW'(num_r[ge]);
            dx = RW'(den2_r);
            bit_q = (sh >= dx);
            rem_nxt[gs][ge] = bit_q ? (sh - dx) : sh;
            quo_nxt[gs][ge] = QW'(bit_q);
          end
        end else begin : g_next
          always_comb begin
            neg_nxt[gs][ge] = neg_r[gs-1][ge];
            sh = {rem_r[gs-1][ge][RW-2:0], 1'b0};
            dx = RW'(dd_r[gs-1]);
            bit_q = (sh >= dx);
            rem_nxt[gs][ge] = bit_q ? (sh - dx) : sh;
            if (gs == NST - 1) begin
              quo_nxt[gs][ge] = quo_r[gs-1][ge] + QW'(bit_q);
            end else begin
              quo_nxt[gs][ge] = {quo_r[gs-1][ge][QW-2:0], bit_q};
            end
          end
        end
        always_ff @(posedge clk) begin
          rem_r[gs][ge] <= rem_nxt[gs][ge];
          quo_r[gs][ge] <= quo_nxt[gs][ge];
          neg_r[gs][ge] <= neg_nxt[gs][ge];
        end
      end
      if (gs == 0) begin : g_ctl_first
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vd_r[gs] <= 1'b0;
          end else begin
            vd_r[gs] <= v2_r;
          end
          dd_r[gs] <= den2_r;
          zn_r[gs] <= (den2_r == '0);
        end
      end else begin : g_ctl_next
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vd_r[gs] <= 1'b0;
          end else begin
            vd_r[gs] <= vd_r[gs-1];
          end
          dd_r[gs] <= dd_r[gs-1];
          zn_r[gs] <= zn_r[gs-1];
        end
      end
    end
  endgenerate

  // sign, identity override and output register
  localparam logic [QW-1:0] ONE = QW'(1) << FRAC;
  logic [QW-1:0] res_nxt [0:NE-1];
  logic [QW-1:0] res_r   [0:NE-1];
  logic          ov_r, zn_out_r;

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      if (zn_r[NST-1]) begin
        res_nxt[k] = (k == qrm_pkg::E_C0X || k == qrm_pkg::E_C1Y || k == qrm_pkg::E_C2Z)
                     ? ONE : '0;
      end else if (neg_r[NST-1][k]) begin
        res_nxt[k] = -quo_r[NST-1][k];
      end else begin
        res_nxt[k] = quo_r[NST-1][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= vd_r[NST-1];
    end
    res_r    <= res_nxt;
    zn_out_r <= zn_r[NST-1];
  end

  assign out_valid     = ov_r;
  assign out_zero_norm = zn_out_r;
  assign out_col0_x    = res_r[qrm_pkg::E_C0X];
  assign out_col0_y    = res_r[qrm_pkg::E_C0Y];
  assign out_col0_z    = res_r[qrm_pkg::E_C0Z];
  assign out_col1_x    = res_r[qrm_pkg::E_C1X];
  assign out_col1_y    = res_r[qrm_pkg::E_C1Y];
  assign out_col1_z    = res_r[qrm_pkg::E_C1Z];
  assign out_col2_x    = res_r[qrm_pkg::E_C2X];
  assign out_col2_y    = res_r[qrm_pkg::E_C2Y];
  assign out_col2_z    = res_r[qrm_pkg::E_C2Z];

  `QRM_ASSERT_DLY(a_start_lat, start, LAT, out_valid, "transfer lost in pipeline")
  `QRM_ASSERT_DLY(a_no_ghost, !start, LAT, !out_valid, "result without a started item")
  `QRM_ASSERT_IMP(a_identity, out_valid && out_zero_norm, out_col0_x == ONE && out_col0_y == '0 && out_col1_x == '0, "zero norm without identity")
endmodule
`default_nettype wire
